// ===== rtl/core/cse_pkg.sv =====
`default_nettype none

package cse_pkg;

  localparam int MAX_DIMENSIONS = 4;
  localparam int MAX_DEGREE     = 63;
  localparam int NUM_DEGREES    = 4;

  localparam int DIM_W   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int FILL_W  = $clog2(MAX_DEGREE + 2);
  localparam int ROW_SIZE    = 2 ** DEG_W;
  localparam int TABLE_DEPTH = MAX_DIMENSIONS * ROW_SIZE;
  localparam int ADDR_W      = DIM_W + DEG_W;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TERM   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         dimension_index;
    logic signed [31:0] x_value;
    logic signed [31:0] coefficient;
    logic [5:0]         degree_0;
    logic [5:0]         degree_1;
    logic [5:0]         degree_2;
    logic [5:0]         degree_3;
  } cmd_t;

  typedef struct packed {
    logic signed [63:0] series_sum;
    logic               saturated;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/cse_mul.sv =====
`default_nettype none

// shared signed 32x32 multiplier, product registered
module cse_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/chebyshev_series_evaluator.sv =====
`default_nettype none

// channel   direction  handshake               beat
// cmd       in         cmd_valid / cmd_stall   cse_pkg::cmd_t (load, term, finish)
// sum       out        sum_valid / sum_stall   cse_pkg::result_t (on finish only)
// cfg       in         cfg_write               cfg_data = dimensions_used
//
// load and finish are handled in the idle state; command 3 is dropped there too
// a term walks the used dimensions, reading a cached degree from the table or extending
//   the row by the recurrence, then multiplies; all products use the one shared multiplier
// the Chebyshev table is one memory, read one entry a cycle with registered data
// rst is synchronous: sum, flag, coordinates and table fill clear at once
// a finish waits while a previous sum beat is still stalled; other commands do not

module chebyshev_series_evaluator (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire cse_pkg::cmd_t   cmd,
  output logic                 sum_valid,
  input  wire logic            sum_stall,
  output cse_pkg::result_t     sum,
  input  wire logic            cfg_write,
  input  wire logic [2:0]      cfg_data
);

  localparam int DIM_W  = cse_pkg::DIM_W;
  localparam int DEG_W  = cse_pkg::DEG_W;
  localparam int FILL_W = cse_pkg::FILL_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DIM       = 4'd1;
  localparam logic [3:0] ST_VAL_WAIT  = 4'd2;
  localparam logic [3:0] ST_PREV_WAIT = 4'd3;
  localparam logic [3:0] ST_CUR_WAIT  = 4'd4;
  localparam logic [3:0] ST_EXT_MUL   = 4'd5;
  localparam logic [3:0] ST_EXT_ADD   = 4'd6;
  localparam logic [3:0] ST_PRD_MUL   = 4'd7;
  localparam logic [3:0] ST_PRD_ACC   = 4'd8;
  localparam logic [3:0] ST_TRM_MUL   = 4'd9;
  localparam logic [3:0] ST_TRM_ACC   = 4'd10;

  // where a fetched table value comes from
  localparam logic [1:0] FSEL_ONE = 2'd0;
  localparam logic [1:0] FSEL_X   = 2'd1;
  localparam logic [1:0] FSEL_MEM = 2'd2;

  localparam logic signed [31:0] ONE_S130 = 32'sh4000_0000;
  localparam logic signed [63:0] S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN  = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] RND29    = 64'sh0000_0000_1000_0000;
  localparam logic signed [63:0] RND30    = 64'sh0000_0000_2000_0000;
  localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // architectural state
  logic [2:0]         dimensions_used;
  logic signed [31:0] coord [cse_pkg::MAX_DIMENSIONS];
  logic [FILL_W-1:0]  fill  [cse_pkg::MAX_DIMENSIONS];
  logic signed [63:0] acc;
  logic               sat_flag;

  // per-term working registers
  logic [3:0]         state;
  logic [DIM_W-1:0]   d_cur;
  logic [DIM_W-1:0]   dims_last;
  logic [DEG_W-1:0]   n_q;
  logic [FILL_W-1:0]  i_q;
  logic signed [31:0] coef_q;
  logic [5:0]         deg_q [cse_pkg::NUM_DEGREES];
  logic signed [31:0] prod;
  logic signed [31:0] tval;
  logic signed [31:0] prev;
  logic signed [31:0] cur;

  // table memory
  logic signed [31:0] mem [cse_pkg::TABLE_DEPTH];
  logic signed [31:0] mem_q;
  logic [1:0]         fsel_q;
  logic [DEG_W-1:0]   rd_idx;
  logic [1:0]         fsel_next;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  logic               cmd_accept;
  logic               sum_take;
  logic signed [31:0] x_cur;
  logic [FILL_W-1:0]  fill_cur;
  logic [FILL_W-1:0]  fill_eff;
  logic [DEG_W-1:0]   n_clamp;
  logic               hit;
  logic signed [31:0] fetched;
  logic signed [63:0] ext_two;
  logic signed [31:0] ext_new;
  logic signed [63:0] prd_rnd;
  logic signed [63:0] acc_sum;
  logic               acc_ovf;
  logic [3:0]         dims_clamp;

  cse_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // a finish needs the output register free (or draining this cycle)
  assign cmd_stall  = (state != ST_IDLE) ||
                      (sum_valid && sum_stall && (cmd.command == cse_pkg::CMD_FINISH));
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign sum_take   = sum_valid && !sum_stall;

  // dimension currently being worked on
  assign x_cur    = coord[d_cur];
  assign fill_cur = fill[d_cur];
  assign fill_eff = (fill_cur < FILL_W'(2)) ? FILL_W'(2) : fill_cur;

  always_comb begin
    logic [5:0] deg;
    deg = deg_q[d_cur];
    if (int'(deg) > cse_pkg::MAX_DEGREE) begin
      n_clamp = DEG_W'(cse_pkg::MAX_DEGREE);
    end else begin
      n_clamp = DEG_W'(deg);
    end
  end

  assign hit = {1'b0, n_clamp} < fill_eff;

  // read address: the wanted degree on a hit, else T(fill-2) then T(fill-1)
  always_comb begin
    case (state)
      ST_DIM: begin
        rd_idx = hit ? n_clamp : DEG_W'(fill_eff - FILL_W'(2));
      end
      ST_PREV_WAIT: begin
        rd_idx = DEG_W'(i_q - FILL_W'(1));
      end
      default: begin
        rd_idx = '0;
      end
    endcase
    if (rd_idx == DEG_W'(0)) begin
      fsel_next = FSEL_ONE;
    end else if (rd_idx == DEG_W'(1)) begin
      fsel_next = FSEL_X;
    end else begin
      fsel_next = FSEL_MEM;
    end
  end

  // T0 and T1 never live in memory: they come from the constant and the coordinate
  always_comb begin
    case (fsel_q)
      FSEL_ONE: fetched = ONE_S130;
      FSEL_X:   fetched = x_cur;
      default:  fetched = mem_q;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    case (state)
      ST_PRD_MUL: begin
        mul_a = prod;
        mul_b = tval;
      end
      ST_TRM_MUL: begin
        mul_a = coef_q;
        mul_b = prod;
      end
      default: begin
        mul_a = x_cur;
        mul_b = cur;
      end
    endcase
  end

  // recurrence step: 2*x*T(n) rounded half up, minus T(n-1), saturated
  assign ext_two = (mul_p + RND29) >>> 29;
  assign ext_new = sat32(ext_two - 64'(prev));

  // running product rounding
  assign prd_rnd = (mul_p + RND30) >>> 30;

  // saturating accumulate
  assign acc_sum = acc + mul_p;
  assign acc_ovf = (acc[63] == mul_p[63]) && (acc_sum[63] != acc[63]);

  // dimensions_used of 0 acts as 1, above the limit as the limit
  always_comb begin
    if (dimensions_used == 3'd0) begin
      dims_clamp = 4'd1;
    end else if (int'(dimensions_used) > cse_pkg::MAX_DIMENSIONS) begin
      dims_clamp = 4'(cse_pkg::MAX_DIMENSIONS);
    end else begin
      dims_clamp = {1'b0, dimensions_used};
    end
    if (int'(dims_clamp) > cse_pkg::NUM_DEGREES) begin
      dims_clamp = 4'(cse_pkg::NUM_DEGREES);
    end
  end

  // table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (state == ST_EXT_ADD) begin
      mem[{d_cur, i_q[DEG_W-1:0]}] <= ext_new;
    end
    mem_q  <= mem[{d_cur, rd_idx}];
    fsel_q <= fsel_next;
  end

  // payload registers of the term in flight
  always_ff @(posedge clk) begin
    if (cmd_accept && (cmd.command == cse_pkg::CMD_TERM)) begin
      coef_q   <= cmd.coefficient;
      deg_q[0] <= cmd.degree_0;
      deg_q[1] <= cmd.degree_1;
      deg_q[2] <= cmd.degree_2;
      deg_q[3] <= cmd.degree_3;
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      dimensions_used <= 3'd1;
      acc             <= '0;
      sat_flag        <= 1'b0;
      sum_valid       <= 1'b0;
      d_cur           <= '0;
      dims_last       <= '0;
      for (int k = 0; k < cse_pkg::MAX_DIMENSIONS; k++) begin
        coord[k] <= '0;
        fill[k]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        dimensions_used <= cfg_data;
      end
      // a finish taken in the same cycle loads the next beat instead
      if (sum_take && !(cmd_accept && (cmd.command == cse_pkg::CMD_FINISH))) begin
        sum_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_accept) begin
            case (cmd.command)
              cse_pkg::CMD_LOAD: begin
                if (int'(cmd.dimension_index) < cse_pkg::MAX_DIMENSIONS) begin
                  coord[DIM_W'(cmd.dimension_index)] <= cmd.x_value;
                  fill[DIM_W'(cmd.dimension_index)]  <= FILL_W'(2);
                end
              end
              cse_pkg::CMD_TERM: begin
                state     <= ST_DIM;
                d_cur     <= '0;
                dims_last <= DIM_W'(dims_clamp - 4'd1);
                prod      <= ONE_S130;
              end
              cse_pkg::CMD_FINISH: begin
                sum_valid          <= 1'b1;
                sum.series_sum     <= acc;
                sum.saturated      <= sat_flag;
                acc                <= '0;
                sat_flag           <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIM: begin
          n_q <= n_clamp;
          i_q <= fill_eff;
          // an unloaded dimension starts from its stored coordinate
          if (fill_cur < FILL_W'(2)) begin
            fill[d_cur] <= FILL_W'(2);
          end
          state <= hit ? ST_VAL_WAIT : ST_PREV_WAIT;
        end
        ST_VAL_WAIT: begin
          tval  <= fetched;
          state <= ST_PRD_MUL;
        end
        ST_PREV_WAIT: begin
          prev  <= fetched;
          state <= ST_CUR_WAIT;
        end
        ST_CUR_WAIT: begin
          cur   <= fetched;
          state <= ST_EXT_MUL;
        end
        ST_EXT_MUL: begin
          state <= ST_EXT_ADD;
        end
        ST_EXT_ADD: begin
          prev <= cur;
          cur  <= ext_new;
          if (i_q == {1'b0, n_q}) begin
            fill[d_cur] <= i_q + FILL_W'(1);
            tval        <= ext_new;
            state       <= ST_PRD_MUL;
          end else begin
            i_q   <= i_q + FILL_W'(1);
            state <= ST_EXT_MUL;
          end
        end
        ST_PRD_MUL: begin
          state <= ST_PRD_ACC;
        end
        ST_PRD_ACC: begin
          prod <= sat32(prd_rnd);
          if (d_cur == dims_last) begin
            state <= ST_TRM_MUL;
          end else begin
            d_cur <= d_cur + DIM_W'(1);
            state <= ST_DIM;
          end
        end
        ST_TRM_MUL: begin
          state <= ST_TRM_ACC;
        end
        ST_TRM_ACC: begin
          if (acc_ovf) begin
            acc      <= mul_p[63] ? S64_MIN : S64_MAX;
            sat_flag <= 1'b1;
          end else begin
            acc <= acc_sum;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the recurrence never runs past the requested degree
  a_ext_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXT_MUL) |-> (i_q <= {1'b0, n_q}))
    else $error("table extension ran past requested degree");

  // the dimension walk stays inside the used dimensions
  a_dim_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (d_cur <= dims_last))
    else $error("dimension counter beyond used dimensions");

  // a stalled sum beat is never dropped or replaced by a later finish
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && sum_stall) |=> (sum_valid && $stable(sum)))
    else $error("stalled sum beat lost");

  // accumulation only follows the coefficient multiply
  a_trm_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRM_ACC) |-> ($past(state) == ST_TRM_MUL))
    else $error("accumulate without coefficient product");
`endif

endmodule

`default_nettype wire

// ===== sim/chebyshev_series_evaluator_test.sv =====
module chebyshev_series_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // command 3 is dropped by the block, it has no name in the package
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // drain wait covers the worst term: every dimension extended from T2 up to the top degree
  localparam int     DRAIN_CYCLES    = 600;
  localparam int     HOLD_CYCLES     = 2000;
  localparam int     ITEMS_PER_PHASE = 135;
  localparam longint TIMEOUT_NS      = 64'd50_000_000;

  localparam logic signed [31:0] ONE_S130 = 32'sh4000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SUM_MAX  = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SUM_MIN  = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {ROW_STEP, ROW_CHECKED, ROW_CFG} row_kind_e;

  // one line of the directed script: a command beat, a checked beat or a register write
  typedef struct packed {
    row_kind_e        kind;
    logic [2:0]       dims;
    cse_pkg::cmd_t    beat;
    cse_pkg::result_t want;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             cmd_valid;
  logic             cmd_stall;
  cse_pkg::cmd_t    cmd;
  logic             sum_valid;
  logic             sum_stall;
  cse_pkg::result_t sum;
  logic             cfg_write;
  logic [2:0]       cfg_data;

  chebyshev_series_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sum       (sum),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // series predictor: own copy of coordinates, cached T rows, sum and flag
  // ---------------------------------------------------------------------------
  logic signed [31:0] coord_q   [cse_pkg::MAX_DIMENSIONS];
  logic signed [31:0] cheb_tab  [cse_pkg::MAX_DIMENSIONS][cse_pkg::MAX_DEGREE + 1];
  int                 cheb_fill [cse_pkg::MAX_DIMENSIONS];
  logic signed [63:0] series_acc;
  logic               series_sat;
  logic [2:0]         dims_cfg;

  // sums still owed by the block, oldest first
  cse_pkg::result_t pending_sums [$];

  int  errors;
  int  items_sent;
  int  n_loads;
  int  n_terms;
  int  n_finishes;
  int  n_settings;
  int  sums_checked;
  int  sat_seen;
  bit  quiet;
  bit  hold_off_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_series_model();
    foreach (coord_q[d]) begin
      coord_q[d]   = '0;
      cheb_fill[d] = 0;
    end
    series_acc = '0;
    series_sat = 1'b0;
    dims_cfg   = 3'd1;
  endfunction

  function automatic logic signed [31:0] sat_word(longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return v[31:0];
  endfunction

  // T0 = 1, T1 = x, as a load does
  function automatic void seed_row(int d);
    cheb_tab[d][0] = ONE_S130;
    cheb_tab[d][1] = coord_q[d];
    cheb_fill[d]   = 2;
  endfunction

  // extend row d up to degree n with T(n+1) = 2x T(n) - T(n-1)
  function automatic logic signed [31:0] cheb_value(int d, int n);
    longint twice_xt;
    if (cheb_fill[d] < 2) seed_row(d);
    for (int i = cheb_fill[d]; i <= n; i++) begin
      // 2x T rounds half up: add half an lsb at bit 28, then floor
      twice_xt = (longint'(coord_q[d]) * longint'(cheb_tab[d][i-1]) + 64'sd268435456) >>> 29;
      cheb_tab[d][i] = sat_word(twice_xt - longint'(cheb_tab[d][i-2]));
    end
    if (n + 1 > cheb_fill[d]) cheb_fill[d] = n + 1;
    return cheb_tab[d][n];
  endfunction

  function automatic void add_term(cse_pkg::cmd_t c);
    logic signed [31:0] prod;
    logic signed [63:0] term;
    logic signed [64:0] wide;
    int                 degs [cse_pkg::NUM_DEGREES];
    int                 span;
    int                 n;
    degs = '{int'(c.degree_0), int'(c.degree_1), int'(c.degree_2), int'(c.degree_3)};
    // a setting of zero behaves as one, anything past the top as the top
    span = (dims_cfg == 3'd0) ? 1
         : (int'(dims_cfg) > cse_pkg::MAX_DIMENSIONS) ? cse_pkg::MAX_DIMENSIONS
         : int'(dims_cfg);
    prod = ONE_S130;
    for (int d = 0; d < span; d++) begin
      n    = (degs[d] > cse_pkg::MAX_DEGREE) ? cse_pkg::MAX_DEGREE : degs[d];
      prod = sat_word((longint'(prod) * longint'(cheb_value(d, n)) + 64'sd536870912) >>> 30);
    end
    term = longint'($signed(c.coefficient)) * longint'(prod);
    wide = series_acc;
    wide = wide + term;
    if (wide[64] != wide[63]) begin
      series_acc = wide[64] ? SUM_MIN : SUM_MAX;
      series_sat = 1'b1;
    end else begin
      series_acc = wide[63:0];
    end
  endfunction

  // advance the predictor by one accepted beat; returns 1 when a sum is owed
  function automatic bit series_step(cse_pkg::cmd_t c, output cse_pkg::result_t r);
    r = '0;
    case (c.command)
      cse_pkg::CMD_LOAD: begin
        if (int'(c.dimension_index) < cse_pkg::MAX_DIMENSIONS) begin
          coord_q[c.dimension_index] = $signed(c.x_value);
          seed_row(int'(c.dimension_index));
        end
      end
      cse_pkg::CMD_TERM: add_term(c);
      cse_pkg::CMD_FINISH: begin
        r.series_sum = series_acc;
        r.saturated  = series_sat;
        series_acc   = '0;
        series_sat   = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // beat builders: fields a command ignores still carry random bits
  // ---------------------------------------------------------------------------
  function automatic cse_pkg::cmd_t junk_cmd(logic [1:0] op);
    cse_pkg::cmd_t c;
    c.command         = op;
    c.dimension_index = 2'($urandom);
    c.x_value         = $urandom;
    c.coefficient     = $urandom;
    c.degree_0        = 6'($urandom);
    c.degree_1        = 6'($urandom);
    c.degree_2        = 6'($urandom);
    c.degree_3        = 6'($urandom);
    return c;
  endfunction

  function automatic cse_pkg::cmd_t load_cmd(logic [1:0] idx, logic [31:0] x);
    cse_pkg::cmd_t c;
    c                 = junk_cmd(cse_pkg::CMD_LOAD);
    c.dimension_index = idx;
    c.x_value         = x;
    return c;
  endfunction

  function automatic cse_pkg::cmd_t term_cmd(logic [31:0] k,
                                             logic [5:0] d0, logic [5:0] d1,
                                             logic [5:0] d2, logic [5:0] d3);
    cse_pkg::cmd_t c;
    c             = junk_cmd(cse_pkg::CMD_TERM);
    c.coefficient = k;
    c.degree_0    = d0;
    c.degree_1    = d1;
    c.degree_2    = d2;
    c.degree_3    = d3;
    return c;
  endfunction

  // coordinates mostly inside [-1, 1], now and then the rails or any 32-bit word
  function automatic logic [31:0] rand_x();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h4000_0000;
          1:       return 32'hc000_0000;
          2:       return 32'h7fff_ffff;
          3:       return 32'h8000_0000;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0001_0000;
      default: return 32'hffff_0000;
    endcase
  endfunction

  // low degrees keep terms short; the full range shows up one time in eight
  function automatic logic [5:0] rand_degree();
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 7));
  endfunction

  function automatic directed_row_t step_row(cse_pkg::cmd_t c);
    directed_row_t r;
    r      = '0;
    r.kind = ROW_STEP;
    r.beat = c;
    return r;
  endfunction

  function automatic directed_row_t checked_row(cse_pkg::cmd_t c, logic signed [63:0] s,
                                                logic f);
    directed_row_t r;
    r                 = '0;
    r.kind            = ROW_CHECKED;
    r.beat            = c;
    r.want.series_sum = s;
    r.want.saturated  = f;
    return r;
  endfunction

  function automatic directed_row_t cfg_row(logic [2:0] v);
    directed_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.dims = v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offer one beat, hold it until taken, then predict; valid is only lowered for a gap
  task automatic send(cse_pkg::cmd_t c, bit typed = 1'b0, cse_pkg::result_t want = '0);
    cse_pkg::result_t r;
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (series_step(c, r)) begin
      if (typed) r = want;
      pending_sums = {pending_sums, r};
    end
    case (c.command)
      cse_pkg::CMD_LOAD:   n_loads++;
      cse_pkg::CMD_TERM:   n_terms++;
      cse_pkg::CMD_FINISH: n_finishes++;
      default:             ;
    endcase
    if (c.command != CMD_UNUSED) items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // register writes only when idle: every sum back, then room for a last term to finish
  task automatic set_dimensions(logic [2:0] v);
    cmd_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    dims_cfg = v;
    n_settings++;
  endtask

  // one series: some loads, a run of terms, a finish, with a little noise mixed in
  task automatic run_series();
    logic [31:0] k;
    for (int d = 0; d < cse_pkg::MAX_DIMENSIONS; d++)
      if ($urandom_range(0, 2) != 0) send(load_cmd(2'(d), rand_x()));
    if ($urandom_range(0, 5) == 0) begin
      // full-scale terms of one sign at degree zero drive the sum onto a rail
      k = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      repeat (6) send(term_cmd(k, 6'd0, 6'd0, 6'd0, 6'd0));
    end
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 19))
        0:       send(load_cmd(2'($urandom), rand_x()));
        1:       send(junk_cmd(CMD_UNUSED));
        2:       send(junk_cmd(cse_pkg::CMD_FINISH));
        default: send(term_cmd(rand_coef(), rand_degree(), rand_degree(), rand_degree(),
                               rand_degree()));
      endcase
    end
    send(junk_cmd(cse_pkg::CMD_FINISH));
  endtask

  initial begin : stimulus
    directed_row_t script [$];
    logic [2:0]    plan [8];
    int            base;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    reset_series_model();

    // directed script: results typed in where they are obvious, the rest predicted
    // nothing accumulated straight after reset
    script = {script, checked_row(junk_cmd(cse_pkg::CMD_FINISH), 64'sd0, 1'b0)};
    // term on a dimension never loaded: coordinate zero, T0 = 1
    script = {script, step_row(term_cmd(32'h0001_0000, 6'd0, 6'd0, 6'd0, 6'd0))};
    script = {script, checked_row(junk_cmd(cse_pkg::CMD_FINISH), 64'sh0000_4000_0000_0000,
                                  1'b0)};
    // top degree on the unloaded row, then again after a load of +1.0
    script = {script, step_row(term_cmd(32'h0001_0000, 6'd63, 6'd0, 6'd0, 6'd0))};
    script = {script, step_row(load_cmd(2'd0, 32'h4000_0000))};
    script = {script, step_row(term_cmd(32'hffff_0000, 6'd63, 6'd63, 6'd63, 6'd63))};
    script = {script, step_row(junk_cmd(cse_pkg::CMD_FINISH))};
    // all four dimensions, coordinates at -1.0 and past both rails
    script = {script, cfg_row(3'd4)};
    script = {script, step_row(load_cmd(2'd1, 32'hc000_0000))};
    script = {script, step_row(load_cmd(2'd2, 32'h7fff_ffff))};
    script = {script, step_row(load_cmd(2'd3, 32'h8000_0000))};
    script = {script, step_row(term_cmd(32'h7fff_ffff, 6'd63, 6'd63, 6'd63, 6'd63))};
    script = {script, step_row(term_cmd(32'h8000_0000, 6'd1, 6'd2, 6'd3, 6'd5))};
    // unknown command in the middle of a series
    script = {script, step_row(junk_cmd(CMD_UNUSED))};
    script = {script, step_row(junk_cmd(cse_pkg::CMD_FINISH))};
    // four of -2^61 land exactly on the lower rail, the fifth saturates
    script = {script, cfg_row(3'd1)};
    for (int i = 0; i < 5; i++)
      script = {script, step_row(term_cmd(32'h8000_0000, 6'd0, 6'd0, 6'd0, 6'd0))};
    script = {script, checked_row(junk_cmd(cse_pkg::CMD_FINISH), SUM_MIN, 1'b1)};
    // finish cleared both sum and flag
    script = {script, checked_row(junk_cmd(cse_pkg::CMD_FINISH), 64'sd0, 1'b0)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG:     set_dimensions(script[i].dims);
        ROW_CHECKED: send(script[i].beat, 1'b1, script[i].want);
        default:     send(script[i].beat);
      endcase
    end

    // random phases, one dimension setting each, extremes of the register included
    plan = '{3'd7, 3'd0, 3'd4, 3'd2, 3'd1, 3'd3, 3'($urandom), 3'd5};
    base = items_sent;
    foreach (plan[p]) begin
      set_dimensions(plan[p]);
      if (p == $size(plan) - 1) quiet = 1'b1;
      if (p == 2) begin
        // receiver goes deaf for a long while; three finishes and a term back the block up
        hold_off_req = 1'b1;
        send(junk_cmd(cse_pkg::CMD_FINISH));
        send(term_cmd(rand_coef(), rand_degree(), rand_degree(), rand_degree(),
                      rand_degree()));
        send(junk_cmd(cse_pkg::CMD_FINISH));
        send(junk_cmd(cse_pkg::CMD_FINISH));
      end
      while (items_sent < base + (p + 1) * ITEMS_PER_PHASE) run_series();
    end

    cmd_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d terms, %0d finishes over %0d dimension settings",
             n_loads, n_terms, n_finishes, n_settings);
    $display("%0d sums compared, %0d of them on a saturated series", sums_checked, sat_seen);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sum side: random stall bursts, one long hold-off on request, none at the end
  // ---------------------------------------------------------------------------
  initial begin : receiver
    sum_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        sum_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sum_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
        sum_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        sum_stall <= 1'b0;
      end
    end
  end

  // every sum beat taken is matched against the oldest owed sum
  always @(posedge clk) begin : sum_check
    cse_pkg::result_t want;
    if (!rst && sum_valid && !sum_stall) begin
      if (pending_sums.size() == 0) begin
        $error("sum beat with no finish outstanding: series_sum %0d saturated %0b",
               $signed(sum.series_sum), sum.saturated);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (sum.series_sum !== want.series_sum) begin
          $error("series_sum: expected %0d, got %0d",
                 $signed(want.series_sum), $signed(sum.series_sum));
          errors++;
        end
        if (sum.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, sum.saturated);
          errors++;
        end
        sums_checked++;
        if (want.saturated) sat_seen++;
      end
    end
  end

  // safety net far beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
